/* rtl/ptts_pkg.sv */
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int MAX_DISPATCH = 8;
   localparam int N_W          = 4;

   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_CREATE   = 2'd1;
   localparam logic [1:0] KIND_DISPATCH = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NULL       = 2'd1;
   localparam logic [1:0] STATUS_PERIOD_BIG = 2'd2;
   localparam logic [1:0] STATUS_FULL       = 2'd3;

   localparam logic [1:0] TASK_BLOCKED   = 2'd0;
   localparam logic [1:0] TASK_READY     = 2'd1;
   localparam logic [1:0] TASK_SUSPENDED = 2'd2;

   localparam logic [1:0] CSR_TICK_DIVIDE   = 2'd0;
   localparam logic [1:0] CSR_MS_DIVIDE     = 2'd1;
   localparam logic [1:0] CSR_MAX_PERIOD    = 2'd2;
   localparam logic [1:0] CSR_COUNTER_START = 2'd3;

   localparam logic [15:0] TICK_DIVIDE_RST   = 16'd10;
   localparam logic [15:0] MS_DIVIDE_RST     = 16'd1000;
   localparam logic [7:0]  MAX_PERIOD_RST    = 8'd255;
   localparam logic [7:0]  COUNTER_START_RST = 8'd0;

   typedef struct packed {
      logic [7:0] handle;
      logic [7:0] period;
      logic [1:0] state;
      logic [7:0] counter;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_MS,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_RESULT,
      ST_DSP_RD,
      ST_DSP_EVAL,
      ST_DSP_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic tick_sub;
      logic tick_ms;
      logic create;
      logic walk_start;
      logic ram_rd;
      logic upd_wr;
      logic dsp_take;
      logic push_pend;
      logic idx_inc;
      logic out_single;
      logic out_flush;
   } dp_cmd_type;

   typedef struct packed {
      logic sec_fire;
      logic tbl_empty;
      logic idx_last;
      logic cap_hit;
      logic slot_ready;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/ptts_ram.sv */
// ----------------------------------------------------------------------------
// ptts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptts_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ptts_ctrl.sv */
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer: item acceptance, per-second slot walk, dispatch walk, results.
// ----------------------------------------------------------------------------
module ptts_ctrl
   import ptts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_kind,
   output logic          req_stall,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_kind)
                  KIND_TICK: begin
                     cmd.tick_sub = 1'b1;
                     state_in     = ST_TICK_MS;
                  end
                  KIND_CREATE: begin
                     cmd.create = 1'b1;
                     state_in   = ST_RESULT;
                  end
                  KIND_DISPATCH: begin
                     cmd.walk_start = 1'b1;
                     state_in       = sts.tbl_empty ? ST_DSP_FLUSH : ST_DSP_RD;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_TICK_MS: begin
            cmd.tick_ms = 1'b1;
            if (sts.sec_fire && !sts.tbl_empty) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_UPD_RD;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_UPD_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cmd.upd_wr = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_RESULT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_UPD_RD;
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.out_single = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_DSP_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = ST_DSP_EVAL;
         end
         ST_DSP_EVAL: begin
            if (!(sts.slot_ready && sts.pend_valid && !sts.out_free)) begin
               if (sts.slot_ready) begin
                  cmd.dsp_take  = 1'b1;
                  cmd.push_pend = sts.pend_valid;
               end
               if (sts.idx_last || (sts.slot_ready && sts.cap_hit)) begin
                  state_in = ST_DSP_FLUSH;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_DSP_RD;
               end
            end
         end
         ST_DSP_FLUSH: begin
            if (sts.out_free) begin
               cmd.out_flush = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/ptts_dp.sv */
// ----------------------------------------------------------------------------
// ptts_dp
// Datapath: config registers, prescaler, task table, walk index, result regs.
// ----------------------------------------------------------------------------
module ptts_dp
   import ptts_pkg::*;
#(
   parameter int NUM_TASKS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type sts,
   input  logic [7:0]    req_task_handle,
   input  logic [7:0]    req_period,
   input  logic [1:0]    req_start_state,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic          rsp_dispatched,
   output logic [7:0]    rsp_run_handle,
   output logic [2:0]    rsp_run_slot,
   output logic          rsp_second_elapsed,
   output logic          rsp_last
);

   localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CNT_W  = $clog2(NUM_TASKS + 1);
   localparam int WORD_W = $bits(slot_type);

   logic [15:0] tick_divide_ff, tick_divide_in;
   logic [15:0] ms_divide_ff, ms_divide_in;
   logic [7:0]  max_period_ff, max_period_in;
   logic [7:0]  counter_start_ff, counter_start_in;
   logic [15:0] sub_ms_ff, sub_ms_in;
   logic [15:0] ms_ff, ms_in;
   logic        ms_step_ff, ms_step_in;
   logic [CNT_W-1:0]  created_ff, created_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_handle_ff, pend_handle_in;
   logic [2:0]  pend_slot_ff, pend_slot_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        res_sec_ff, res_sec_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic        out_disp_ff, out_disp_in;
   logic [7:0]  out_handle_ff, out_handle_in;
   logic [2:0]  out_slot_ff, out_slot_in;
   logic        out_sec_ff, out_sec_in;
   logic        out_last_ff, out_last_in;

   logic [15:0] sub_sum;
   logic [15:0] ms_sum;
   logic        sub_wrap;
   logic        sec_fire;
   logic [1:0]  create_status;
   logic        out_free;

   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   slot_type          ram_wr_word;
   logic [WORD_W-1:0] ram_rd_data;
   slot_type          rd_word;
   slot_type          upd_word;
   slot_type          new_word;

   ptts_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_TASKS),
      .AW    (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (cmd.ram_rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_word  = slot_type'(ram_rd_data);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign sub_sum  = sub_ms_ff + 16'd1;
   assign sub_wrap = (sub_sum >= tick_divide_ff);
   assign ms_sum   = ms_ff + {15'd0, ms_step_ff};
   assign sec_fire = (ms_sum >= ms_divide_ff);

   always_comb begin
      if (req_task_handle == 8'd0) begin
         create_status = STATUS_NULL;
      end else if (req_period > max_period_ff) begin
         create_status = STATUS_PERIOD_BIG;
      end else if (created_ff >= CNT_W'(NUM_TASKS)) begin
         create_status = STATUS_FULL;
      end else begin
         create_status = STATUS_OK;
      end
   end

   always_comb begin
      new_word.handle  = req_task_handle;
      new_word.period  = req_period;
      new_word.state   = req_start_state;
      new_word.counter = counter_start_ff;

      upd_word = rd_word;
      if (rd_word.state != TASK_SUSPENDED) begin
         if (rd_word.counter >= rd_word.period) begin
            upd_word.state   = TASK_READY;
            upd_word.counter = counter_start_ff;
         end else begin
            upd_word.counter = rd_word.counter + 8'd1;
         end
      end

      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_word = upd_word;
      if (cmd.create) begin
         ram_wr_en   = (create_status == STATUS_OK);
         ram_wr_addr = created_ff[SLOT_W-1:0];
         ram_wr_word = new_word;
      end else if (cmd.upd_wr) begin
         ram_wr_en = 1'b1;
      end else if (cmd.dsp_take) begin
         ram_wr_en         = 1'b1;
         ram_wr_word       = rd_word;
         ram_wr_word.state = TASK_BLOCKED;
      end
   end

   always_comb begin
      sts.sec_fire   = sec_fire;
      sts.tbl_empty  = (created_ff == '0);
      sts.idx_last   = ((CNT_W'(idx_ff) + CNT_W'(1)) == created_ff);
      sts.cap_hit    = (n_ff == N_W'(MAX_DISPATCH - 1));
      sts.slot_ready = (rd_word.state == TASK_READY);
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   assign csr_ready = 1'b1;

   always_comb begin
      tick_divide_in   = tick_divide_ff;
      ms_divide_in     = ms_divide_ff;
      max_period_in    = max_period_ff;
      counter_start_in = counter_start_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TICK_DIVIDE:   tick_divide_in   = csr_wdata;
            CSR_MS_DIVIDE:     ms_divide_in     = csr_wdata;
            CSR_MAX_PERIOD:    max_period_in    = csr_wdata[7:0];
            CSR_COUNTER_START: counter_start_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sub_ms_in      = sub_ms_ff;
      ms_in          = ms_ff;
      ms_step_in     = ms_step_ff;
      created_in     = created_ff;
      idx_in         = idx_ff;
      n_in           = n_ff;
      pend_valid_in  = pend_valid_ff;
      pend_handle_in = pend_handle_ff;
      pend_slot_in   = pend_slot_ff;
      res_status_in  = res_status_ff;
      res_sec_in     = res_sec_ff;

      if (cmd.accept) begin
         res_status_in = cmd.create ? create_status : STATUS_OK;
         res_sec_in    = 1'b0;
      end
      if (cmd.tick_sub) begin
         sub_ms_in  = sub_wrap ? 16'd0 : sub_sum;
         ms_step_in = sub_wrap;
      end
      if (cmd.tick_ms) begin
         ms_in      = sec_fire ? 16'd0 : ms_sum;
         res_sec_in = sec_fire;
      end
      if (cmd.create && (create_status == STATUS_OK)) begin
         created_in = created_ff + CNT_W'(1);
      end
      if (cmd.walk_start) begin
         idx_in        = '0;
         n_in          = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + SLOT_W'(1);
      end
      if (cmd.dsp_take) begin
         pend_valid_in  = 1'b1;
         pend_handle_in = rd_word.handle;
         pend_slot_in   = 3'(idx_ff);
         n_in           = n_ff + N_W'(1);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_disp_in   = out_disp_ff;
      out_handle_in = out_handle_ff;
      out_slot_in   = out_slot_ff;
      out_sec_in    = out_sec_ff;
      out_last_in   = out_last_ff;
      if (cmd.out_single) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_disp_in   = 1'b0;
         out_handle_in = 8'd0;
         out_slot_in   = 3'd0;
         out_sec_in    = res_sec_ff;
         out_last_in   = 1'b1;
      end else if (cmd.push_pend || cmd.out_flush) begin
         out_valid_in  = 1'b1;
         out_status_in = STATUS_OK;
         out_disp_in   = pend_valid_ff;
         out_handle_in = pend_valid_ff ? pend_handle_ff : 8'd0;
         out_slot_in   = pend_valid_ff ? pend_slot_ff : 3'd0;
         out_sec_in    = 1'b0;
         out_last_in   = cmd.out_flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divide_ff   <= TICK_DIVIDE_RST;
         ms_divide_ff     <= MS_DIVIDE_RST;
         max_period_ff    <= MAX_PERIOD_RST;
         counter_start_ff <= COUNTER_START_RST;
         sub_ms_ff        <= '0;
         ms_ff            <= '0;
         created_ff       <= '0;
         pend_valid_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         tick_divide_ff   <= tick_divide_in;
         ms_divide_ff     <= ms_divide_in;
         max_period_ff    <= max_period_in;
         counter_start_ff <= counter_start_in;
         sub_ms_ff        <= sub_ms_in;
         ms_ff            <= ms_in;
         created_ff       <= created_in;
         pend_valid_ff    <= pend_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ms_step_ff     <= ms_step_in;
      idx_ff         <= idx_in;
      n_ff           <= n_in;
      pend_handle_ff <= pend_handle_in;
      pend_slot_ff   <= pend_slot_in;
      res_status_ff  <= res_status_in;
      res_sec_ff     <= res_sec_in;
      out_status_ff  <= out_status_in;
      out_disp_ff    <= out_disp_in;
      out_handle_ff  <= out_handle_in;
      out_slot_ff    <= out_slot_in;
      out_sec_ff     <= out_sec_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_dispatched     = out_disp_ff;
   assign rsp_run_handle     = out_handle_ff;
   assign rsp_run_slot       = out_slot_ff;
   assign rsp_second_elapsed = out_sec_ff;
   assign rsp_last           = out_last_ff;

endmodule

/* rtl/periodic_task_tick_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Create and unused kinds go straight to the result state; a tick steps the
// prescaler and, on a second, walks each created task (one read, one write).
// Dispatch reads and evaluates each slot walked; one item in flight at a time.
// Reset: synchronous, active high; config returns to defaults, table emptied.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler
   import ptts_pkg::*;
#(
   parameter int NUM_TASKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_task_handle,
   input  logic [7:0]  req_period,
   input  logic [1:0]  req_start_state,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_dispatched,
   output logic [7:0]  rsp_run_handle,
   output logic [2:0]  rsp_run_slot,
   output logic        rsp_second_elapsed,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type sts;

   ptts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptts_dp #(
      .NUM_TASKS (NUM_TASKS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_task_handle    (req_task_handle),
      .req_period         (req_period),
      .req_start_state    (req_start_state),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_dispatched     (rsp_dispatched),
      .rsp_run_handle     (rsp_run_handle),
      .rsp_run_slot       (rsp_run_slot),
      .rsp_second_elapsed (rsp_second_elapsed),
      .rsp_last           (rsp_last)
   );

endmodule

/* rtl/ptts_checker.sv */
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ptts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_dispatched,
   input logic [7:0]  rsp_run_handle,
   input logic [2:0]  rsp_run_slot,
   input logic        rsp_second_elapsed,
   input logic        rsp_last
);

   // no transaction pending right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_handle) &&
      $stable(rsp_last) && $stable(rsp_dispatched) && $stable(rsp_status))
      else $error("stalled result changed");

   // one transaction in flight: busy the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted back to back");

   a_idle_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dispatched |-> rsp_run_handle == 8'd0 && rsp_run_slot == 3'd0
      && rsp_last)
      else $error("non-dispatch result carries a task");

   a_dispatch_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dispatched |-> rsp_status == 2'd0 && !rsp_second_elapsed)
      else $error("dispatch result carries status or second flag");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

/* tb/periodic_task_tick_scheduler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_tb
// Self-checking bench for the tick-driven periodic task scheduler. Items are
// queued per phase, handed to a valid/stall driver and mirrored in a local
// scheduler model that forecasts every result transaction. A monitor checks
// each result transaction against the forecast. Idle gaps and result stalls
// are random. Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_tb
   import ptts_pkg::*;
();

   localparam int TASK_SLOTS    = 8;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 900000;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] TASK_SPARE  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] handle;
      logic [7:0] period;
      logic [1:0] start;
   } sched_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       dispatched;
      logic [7:0] run_handle;
      logic [2:0] run_slot;
      logic       second_elapsed;
      logic       last;
   } sched_result_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind        = '0;
   logic [7:0]  req_task_handle = '0;
   logic [7:0]  req_period      = '0;
   logic [1:0]  req_start_state = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_dispatched;
   logic [7:0]  rsp_run_handle;
   logic [2:0]  rsp_run_slot;
   logic        rsp_second_elapsed;
   logic        rsp_last;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index       = '0;
   logic [15:0] csr_wdata       = '0;

   // scheduler model state
   logic [15:0] tick_div_cfg      = TICK_DIVIDE_RST;
   logic [15:0] ms_div_cfg        = MS_DIVIDE_RST;
   logic [7:0]  max_period_cfg    = MAX_PERIOD_RST;
   logic [7:0]  counter_start_cfg = COUNTER_START_RST;
   logic [15:0] sub_ms_cnt        = '0;
   logic [15:0] ms_cnt            = '0;
   int unsigned tasks_made        = 0;
   slot_type    task_table [TASK_SLOTS];

   sched_item_type   item_backlog [$];
   sched_result_type due_results [$];
   sched_item_type   on_bus;
   sched_result_type head_result;
   int unsigned   items_sent  = 0;
   int unsigned   items_taken = 0;
   int unsigned   errors      = 0;
   int unsigned   cycles      = 0;
   int unsigned   req_gap     = 0;
   int unsigned   stall_left  = 0;
   bit            idle_on     = 1'b1;
   bit            stall_on    = 1'b1;

   periodic_task_tick_scheduler #(.NUM_TASKS(TASK_SLOTS)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic advance_second();
      int unsigned s;
      for (s = 0; s < tasks_made; s++) begin
         if (task_table[s].state != TASK_SUSPENDED) begin
            if (task_table[s].counter >= task_table[s].period) begin
               task_table[s].state   = TASK_READY;
               task_table[s].counter = counter_start_cfg;
            end else begin
               task_table[s].counter = task_table[s].counter + 8'd1;
            end
         end
      end
   endtask

   task automatic forecast_results(input sched_item_type it);
      sched_result_type r;
      sched_result_type held;
      bit            have_held;
      int unsigned   s;
      int unsigned   shown;
      r         = '0;
      r.last    = 1'b1;
      held      = '0;
      have_held = 1'b0;
      shown     = 0;
      case (it.kind)
         KIND_TICK: begin
            sub_ms_cnt = sub_ms_cnt + 16'd1;
            if (sub_ms_cnt >= tick_div_cfg) begin
               sub_ms_cnt = '0;
               ms_cnt     = ms_cnt + 16'd1;
            end
            if (ms_cnt >= ms_div_cfg) begin
               ms_cnt = '0;
               advance_second();
               r.second_elapsed = 1'b1;
            end
            due_results.push_back(r);
         end
         KIND_CREATE: begin
            if (it.handle == 8'd0) begin
               r.status = STATUS_NULL;
            end else if (it.period > max_period_cfg) begin
               r.status = STATUS_PERIOD_BIG;
            end else if (tasks_made >= TASK_SLOTS) begin
               r.status = STATUS_FULL;
            end else begin
               task_table[tasks_made].handle  = it.handle;
               task_table[tasks_made].period  = it.period;
               task_table[tasks_made].state   = it.start;
               task_table[tasks_made].counter = counter_start_cfg;
               tasks_made++;
               r.status = STATUS_OK;
            end
            due_results.push_back(r);
         end
         KIND_DISPATCH: begin
            for (s = 0; s < tasks_made; s++) begin
               if (task_table[s].state == TASK_READY && shown < MAX_DISPATCH) begin
                  task_table[s].state = TASK_BLOCKED;
                  if (have_held) due_results.push_back(held);
                  held            = '0;
                  held.dispatched = 1'b1;
                  held.run_handle = task_table[s].handle;
                  held.run_slot   = s[2:0];
                  have_held       = 1'b1;
                  shown++;
               end
            end
            held.last = 1'b1;
            due_results.push_back(held);
         end
         default: begin
            due_results.push_back(r);
         end
      endcase
   endtask

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         errors++;
      end
   endtask

   task automatic queue_item(input logic [1:0] kind, input logic [7:0] handle,
                             input logic [7:0] period, input logic [1:0] start);
      sched_item_type it;
      it.kind   = kind;
      it.handle = handle;
      it.period = period;
      it.start  = start;
      item_backlog.push_back(it);
      items_sent++;
   endtask

   task automatic queue_random(input int count);
      int          n;
      int unsigned roll;
      logic [1:0]  kind;
      logic [7:0]  handle;
      logic [7:0]  period;
      for (n = 0; n < count; n++) begin
         roll   = $urandom_range(0, 99);
         handle = 8'($urandom_range(0, 255));
         period = 8'($urandom_range(0, 255));
         if (roll < 55) begin
            kind = KIND_TICK;
         end else if (roll < 80) begin
            kind = KIND_DISPATCH;
         end else if (roll < 95) begin
            kind = KIND_CREATE;
            handle = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            if ($urandom_range(0, 9) < 7) period = 8'($urandom_range(0, max_period_cfg));
         end else begin
            kind = KIND_UNUSED;
         end
         queue_item(kind, handle, period, 2'($urandom_range(0, 3)));
      end
   endtask

   task automatic set_config(input logic [15:0] tick_div, input logic [15:0] ms_div,
                             input logic [7:0] max_per, input logic [7:0] cnt_start);
      logic [15:0] value [4];
      int          idx;
      value[CSR_TICK_DIVIDE]   = tick_div;
      value[CSR_MS_DIVIDE]     = ms_div;
      value[CSR_MAX_PERIOD]    = {8'd0, max_per};
      value[CSR_COUNTER_START] = {8'd0, cnt_start};
      for (idx = 0; idx < 4; idx++) begin
         @(posedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx[1:0];
         csr_wdata <= value[idx];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         csr_valid <= 1'b0;
         case (idx[1:0])
            CSR_TICK_DIVIDE:   tick_div_cfg      = value[idx];
            CSR_MS_DIVIDE:     ms_div_cfg        = value[idx];
            CSR_MAX_PERIOD:    max_period_cfg    = value[idx][7:0];
            CSR_COUNTER_START: counter_start_cfg = value[idx][7:0];
            default: ;
         endcase
      end
   endtask

   task automatic wait_idle();
      while (items_taken != items_sent || due_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            forecast_results(on_bus);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap--;
            end else if (item_backlog.size() != 0) begin
               on_bus = item_backlog.pop_front();
               req_kind        <= on_bus.kind;
               req_task_handle <= on_bus.handle;
               req_period      <= on_bus.period;
               req_start_state <= on_bus.start;
               req_valid       <= 1'b1;
               req_gap = pick_gap(idle_on);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status=%0d disp=%0d",
                        $time, rsp_status, rsp_dispatched);
               errors++;
            end else begin
               head_result = due_results.pop_front();
               check_field("status", head_result.status, rsp_status);
               check_field("dispatched", head_result.dispatched, rsp_dispatched);
               check_field("run_handle", head_result.run_handle, rsp_run_handle);
               check_field("run_slot", head_result.run_slot, rsp_run_slot);
               check_field("second_elapsed", head_result.second_elapsed, rsp_second_elapsed);
               check_field("last", head_result.last, rsp_last);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) stall_left = pick_gap(stall_on);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register defaults: ignored kind, empty table, one ready task
      queue_item(KIND_UNUSED, 8'hFF, 8'hFF, TASK_SPARE);
      queue_item(KIND_DISPATCH, 8'h00, 8'h00, TASK_BLOCKED);
      queue_item(KIND_TICK, 8'h00, 8'h00, TASK_BLOCKED);
      queue_item(KIND_CREATE, 8'h00, 8'hFF, TASK_SPARE);
      queue_item(KIND_CREATE, 8'hFF, 8'hFF, TASK_READY);
      queue_item(KIND_DISPATCH, 8'h00, 8'h00, TASK_BLOCKED);
      queue_item(KIND_DISPATCH, 8'h00, 8'h00, TASK_BLOCKED);
      wait_idle();

      // one second per tick; create checks, all start states, full table
      set_config(16'd1, 16'd1, 8'd100, 8'd0);
      queue_item(KIND_CREATE, 8'h00, 8'd200, TASK_BLOCKED);
      queue_item(KIND_CREATE, 8'h01, 8'd101, TASK_BLOCKED);
      queue_item(KIND_CREATE, 8'h02, 8'd0, TASK_BLOCKED);
      queue_item(KIND_CREATE, 8'h03, 8'd100, TASK_SUSPENDED);
      queue_item(KIND_CREATE, 8'h04, 8'd1, TASK_SPARE);
      queue_item(KIND_CREATE, 8'h05, 8'd100, TASK_READY);
      queue_item(KIND_TICK, 8'h00, 8'h00, TASK_BLOCKED);
      queue_item(KIND_TICK, 8'h00, 8'h00, TASK_BLOCKED);
      queue_item(KIND_DISPATCH, 8'h00, 8'h00, TASK_BLOCKED);
      queue_item(KIND_CREATE, 8'h06, 8'd2, TASK_BLOCKED);
      queue_item(KIND_CREATE, 8'h07, 8'd3, TASK_READY);
      queue_item(KIND_CREATE, 8'h80, 8'd0, TASK_SUSPENDED);
      queue_item(KIND_CREATE, 8'h09, 8'd5, TASK_BLOCKED);
      queue_item(KIND_CREATE, 8'h00, 8'd5, TASK_BLOCKED);
      queue_item(KIND_CREATE, 8'h0A, 8'd255, TASK_BLOCKED);
      queue_item(KIND_TICK, 8'h00, 8'h00, TASK_BLOCKED);
      queue_item(KIND_DISPATCH, 8'h00, 8'h00, TASK_BLOCKED);
      wait_idle();

      idle_on  = 1'b0;
      stall_on = 1'b0;
      set_config(16'd1, 16'd1, 8'd255, 8'd0);
      queue_random(50);
      wait_idle();

      idle_on  = 1'b1;
      stall_on = 1'b1;
      set_config(16'd2, 16'd3, 8'd255, 8'd255);
      queue_random(40);
      wait_idle();

      set_config(16'd65535, 16'd65535, 8'd0, 8'd255);
      queue_random(20);
      wait_idle();

      set_config(16'd1, 16'd2, 8'd50, 8'd7);
      queue_random(40);
      wait_idle();

      set_config(16'd3, 16'd1, 8'd200, 8'd0);
      queue_random(40);
      wait_idle();

      set_config(16'd1, 16'd1, 8'd128, 8'd200);
      queue_random(40);
      wait_idle();

      for (p = 0; p < 3; p++) begin
         idle_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         set_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         queue_random(40);
         wait_idle();
      end

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
